// ----- hdl/rc4_stream_cipher_defines.svh -----
// assertion macros for the rc4 stream cipher checker
// expects clk and rst_n in the scope where a macro is used
`ifndef RC4_STREAM_CIPHER_DEFINES_SVH
`define RC4_STREAM_CIPHER_DEFINES_SVH

// property that must hold in the cycle after the trigger
`define RC4_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rc4 checker: next-cycle property failed");

// property that must hold in the same cycle as the trigger
`define RC4_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rc4 checker: same-cycle property failed");

`endif

// ----- hdl/rc4_pkg.sv -----
// shared types, constants and command encodings for the rc4 stream cipher
// no dependencies
`timescale 1ns / 1ps

package rc4_pkg;

    localparam int BYTE_W        = 8;
    localparam int PERM_DEPTH    = 256;
    localparam int PERM_AW       = $clog2(PERM_DEPTH);
    localparam int MAX_KEY_BYTES = 32;
    localparam int KEY_LEN_W     = 6;
    localparam int KEY_WORD_W    = 64;
    localparam int KEY_WORDS     = 4;
    localparam int CFG_IDX_W     = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY_LENGTH = 3'd0,
        CFG_KEY_WORD_0 = 3'd1,
        CFG_KEY_WORD_1 = 3'd2,
        CFG_KEY_WORD_2 = 3'd3,
        CFG_KEY_WORD_3 = 3'd4
    } cfg_index_t;

    // item function codes
    typedef enum logic {
        FUNC_KEY    = 1'b0,
        FUNC_CIPHER = 1'b1
    } func_t;

    // controller states
    typedef enum logic [3:0] {
        ST_RST_FILL,
        ST_IDLE,
        ST_KS_FILL,
        ST_KS_RD_K,
        ST_KS_RD_J,
        ST_KS_WR_K,
        ST_KS_WR_J,
        ST_PR_RD_I,
        ST_PR_RD_J,
        ST_PR_WR_I,
        ST_PR_WR_J
    } state_t;

    typedef enum logic [2:0] {
        RA_CNT,
        RA_INEXT,
        RA_JKS,
        RA_JPR,
        RA_T,
        RA_TREG
    } raddr_sel_t;

    typedef enum logic [1:0] {
        WA_CNT,
        WA_I,
        WA_J
    } waddr_sel_t;

    typedef enum logic [1:0] {
        WD_CNT,
        WD_RDATA,
        WD_SI
    } wdata_sel_t;

    // commands from controller to datapath
    typedef struct packed {
        logic       mem_we;
        waddr_sel_t waddr_sel;
        wdata_sel_t wdata_sel;
        raddr_sel_t raddr_sel;
        logic       cnt_clr;
        logic       cnt_inc;
        logic       kidx_clr;
        logic       kidx_adv;
        logic       i_inc;
        logic       idx_clr;
        logic       j_ks_upd;
        logic       j_pr_upd;
        logic       si_load;
        logic       sj_load;
        logic       t_load;
        logic       in_load;
        logic       out_load;
    } rc4_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic cnt_last;
    } rc4_status_t;

endpackage

// ----- hdl/rc4_stream_cipher.sv -----
// rc4 stream cipher top level: controller, datapath and permutation ram
// depends on rc4_pkg, rc4_ctrl, rc4_datapath, rc4_ram
//
//   channel  | handshake             | payload
//   ---------+-----------------------+------------------------------------
//   input    | in_valid / in_ready   | func, data_in
//   output   | out_valid / out_ready | data_out
//   config   | cfg_we (no wait)      | cfg_index, cfg_data
//
// after reset a pass fills the table with identity; no item is taken meanwhile
// cipher item: reads s[i+1] and s[j], writes the swap back and registers the result;
// no new item is taken before this one is done; the ram has one read and one write port
// key schedule item: identity fill, then one swap per table entry, gives no result
// a result that is not taken holds the block in its last cipher step
`timescale 1ns / 1ps

module rc4_stream_cipher #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           func,
    input  logic [rc4_pkg::BYTE_W-1:0]     data_in,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rc4_pkg::BYTE_W-1:0]     data_out,
    input  logic                           cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rc4_pkg::KEY_WORD_W-1:0] cfg_data
);

    rc4_pkg::rc4_cmd_t    cmd;
    rc4_pkg::rc4_status_t status;

    // sequencer
    rc4_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .func      (func),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // key registers, indices and table
    rc4_datapath #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .data_in   (data_in),
        .cmd       (cmd),
        .status    (status),
        .data_out  (data_out)
    );

endmodule

// ----- hdl/rc4_ram.sv -----
// generic single-write, single-read ram with registered read data
// depends on rc4_pkg for default sizes
`timescale 1ns / 1ps

module rc4_ram #(
    parameter int WIDTH = rc4_pkg::BYTE_W,
    parameter int DEPTH = rc4_pkg::PERM_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port, read returns old data on collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/rc4_datapath.sv -----
// rc4 datapath: key registers, indices, swap holding registers, permutation ram
// depends on rc4_pkg and rc4_ram
`timescale 1ns / 1ps

module rc4_datapath #(
    parameter int MAX_KEY_BYTES = rc4_pkg::MAX_KEY_BYTES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rc4_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [rc4_pkg::KEY_WORD_W-1:0]      cfg_data,
    input  logic [rc4_pkg::BYTE_W-1:0]          data_in,
    input  rc4_pkg::rc4_cmd_t                   cmd,
    output rc4_pkg::rc4_status_t                status,
    output logic [rc4_pkg::BYTE_W-1:0]          data_out
);

    localparam int KIDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
    localparam logic [rc4_pkg::KEY_LEN_W-1:0] MAX_LEN = rc4_pkg::KEY_LEN_W'(MAX_KEY_BYTES);
    localparam int AW = rc4_pkg::PERM_AW;
    localparam int BW = rc4_pkg::BYTE_W;

    logic [rc4_pkg::KEY_LEN_W-1:0]  key_len_reg;
    logic [rc4_pkg::KEY_WORD_W-1:0] key_word_reg [rc4_pkg::KEY_WORDS];
    logic [KIDX_W-1:0]              kidx_reg;
    logic [KIDX_W-1:0]              kidx_next;
    logic [AW-1:0]                  cnt_reg;
    logic [AW-1:0]                  i_reg;
    logic [AW-1:0]                  j_reg;
    logic [BW-1:0]                  si_reg;
    logic [BW-1:0]                  sj_reg;
    logic [AW-1:0]                  t_reg;
    logic [BW-1:0]                  data_reg;
    logic [BW-1:0]                  data_out_reg;

    logic [rc4_pkg::KEY_LEN_W-1:0]  eff_len;
    logic [4:0]                     key_sel;
    logic [rc4_pkg::KEY_WORD_W-1:0] key_word_sel;
    logic [BW-1:0]                  key_byte;
    logic [BW-1:0]                  rdata;
    logic [AW-1:0]                  raddr;
    logic [AW-1:0]                  waddr;
    logic [BW-1:0]                  wdata;
    logic [AW-1:0]                  j_ks;
    logic [AW-1:0]                  j_pr;
    logic [AW-1:0]                  t_comb;
    logic [BW-1:0]                  ks_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_len_reg <= rc4_pkg::KEY_LEN_W'(5);
            for (int w = 0; w < rc4_pkg::KEY_WORDS; w++)
            begin
                key_word_reg[w] <= '0;
            end
        end
        else if (cfg_we)
        begin
            unique case (rc4_pkg::cfg_index_t'(cfg_index))
                rc4_pkg::CFG_KEY_LENGTH: key_len_reg     <= cfg_data[rc4_pkg::KEY_LEN_W-1:0];
                rc4_pkg::CFG_KEY_WORD_0: key_word_reg[0] <= cfg_data;
                rc4_pkg::CFG_KEY_WORD_1: key_word_reg[1] <= cfg_data;
                rc4_pkg::CFG_KEY_WORD_2: key_word_reg[2] <= cfg_data;
                rc4_pkg::CFG_KEY_WORD_3: key_word_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // effective key length: zero acts as one, clipped at the maximum
    always_comb
    begin
        if (key_len_reg == '0)
            eff_len = rc4_pkg::KEY_LEN_W'(1);
        else if (key_len_reg > MAX_LEN)
            eff_len = MAX_LEN;
        else
            eff_len = key_len_reg;
    end

    // key byte selection
    assign key_sel      = 5'(kidx_reg);
    assign key_word_sel = key_word_reg[key_sel[4:3]];
    assign key_byte     = key_word_sel[{key_sel[2:0], 3'b000} +: BW];

    // cyclic key index
    always_comb
    begin
        if ((rc4_pkg::KEY_LEN_W'(kidx_reg) + rc4_pkg::KEY_LEN_W'(1)) >= eff_len)
            kidx_next = '0;
        else
            kidx_next = kidx_reg + KIDX_W'(1);
    end

    // index arithmetic
    assign j_ks   = j_reg + rdata + key_byte;
    assign j_pr   = j_reg + rdata;
    assign t_comb = si_reg + rdata;

    // read address select
    always_comb
    begin
        case (cmd.raddr_sel)
            rc4_pkg::RA_CNT:   raddr = cnt_reg;
            rc4_pkg::RA_INEXT: raddr = i_reg + AW'(1);
            rc4_pkg::RA_JKS:   raddr = j_ks;
            rc4_pkg::RA_JPR:   raddr = j_pr;
            rc4_pkg::RA_T:     raddr = t_comb;
            rc4_pkg::RA_TREG:  raddr = t_reg;
            default:           raddr = cnt_reg;
        endcase
    end

    // write address and data select
    always_comb
    begin
        case (cmd.waddr_sel)
            rc4_pkg::WA_CNT: waddr = cnt_reg;
            rc4_pkg::WA_I:   waddr = i_reg;
            rc4_pkg::WA_J:   waddr = j_reg;
            default:         waddr = cnt_reg;
        endcase
        case (cmd.wdata_sel)
            rc4_pkg::WD_CNT:   wdata = cnt_reg;
            rc4_pkg::WD_RDATA: wdata = rdata;
            rc4_pkg::WD_SI:    wdata = si_reg;
            default:           wdata = cnt_reg;
        endcase
    end

    // keystream byte with forwarding of the swap that is still in flight
    always_comb
    begin
        if (t_reg == j_reg)
            ks_byte = si_reg;
        else if (t_reg == i_reg)
            ks_byte = sj_reg;
        else
            ks_byte = rdata;
    end

    // index and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            kidx_reg <= '0;
        end
        else
        begin
            if (cmd.cnt_clr)
                cnt_reg <= '0;
            else if (cmd.cnt_inc)
                cnt_reg <= cnt_reg + AW'(1);

            if (cmd.idx_clr)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            else
            begin
                if (cmd.i_inc)
                    i_reg <= i_reg + AW'(1);
                if (cmd.j_ks_upd)
                    j_reg <= j_ks;
                else if (cmd.j_pr_upd)
                    j_reg <= j_pr;
            end

            if (cmd.kidx_clr)
                kidx_reg <= '0;
            else if (cmd.kidx_adv)
                kidx_reg <= kidx_next;
        end
    end

    // payload holding registers
    always_ff @(posedge clk)
    begin
        if (cmd.si_load)
            si_reg <= rdata;
        if (cmd.sj_load)
            sj_reg <= rdata;
        if (cmd.t_load)
            t_reg <= t_comb;
        if (cmd.in_load)
            data_reg <= data_in;
        if (cmd.out_load)
            data_out_reg <= data_reg ^ ks_byte;
    end

    // permutation table
    rc4_ram #(
        .WIDTH (BW),
        .DEPTH (rc4_pkg::PERM_DEPTH)
    ) u_perm (
        .clk   (clk),
        .we    (cmd.mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign status.cnt_last = (cnt_reg == {AW{1'b1}});
    assign data_out        = data_out_reg;

endmodule

// ----- hdl/rc4_ctrl.sv -----
// rc4 controller: sequences table fill, key schedule and cipher steps
// depends on rc4_pkg
`timescale 1ns / 1ps

module rc4_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 func,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  rc4_pkg::rc4_status_t status,
    output rc4_pkg::rc4_cmd_t    cmd
);

    rc4_pkg::state_t state_reg;
    rc4_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    // state register and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rc4_pkg::ST_RST_FILL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rc4_pkg::ST_RST_FILL:
            begin
                if (status.cnt_last)
                    state_next = rc4_pkg::ST_IDLE;
            end
            rc4_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (rc4_pkg::func_t'(func) == rc4_pkg::FUNC_KEY)
                        state_next = rc4_pkg::ST_KS_FILL;
                    else
                        state_next = rc4_pkg::ST_PR_RD_I;
                end
            end
            rc4_pkg::ST_KS_FILL:
            begin
                if (status.cnt_last)
                    state_next = rc4_pkg::ST_KS_RD_K;
            end
            rc4_pkg::ST_KS_RD_K: state_next = rc4_pkg::ST_KS_RD_J;
            rc4_pkg::ST_KS_RD_J: state_next = rc4_pkg::ST_KS_WR_K;
            rc4_pkg::ST_KS_WR_K: state_next = rc4_pkg::ST_KS_WR_J;
            rc4_pkg::ST_KS_WR_J:
            begin
                if (status.cnt_last)
                    state_next = rc4_pkg::ST_IDLE;
                else
                    state_next = rc4_pkg::ST_KS_RD_K;
            end
            rc4_pkg::ST_PR_RD_I: state_next = rc4_pkg::ST_PR_RD_J;
            rc4_pkg::ST_PR_RD_J: state_next = rc4_pkg::ST_PR_WR_I;
            rc4_pkg::ST_PR_WR_I: state_next = rc4_pkg::ST_PR_WR_J;
            rc4_pkg::ST_PR_WR_J:
            begin
                if (slot_free)
                    state_next = rc4_pkg::ST_IDLE;
            end
            default: state_next = rc4_pkg::ST_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        unique case (state_reg) inside
            rc4_pkg::ST_RST_FILL, rc4_pkg::ST_KS_FILL:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = rc4_pkg::WA_CNT;
                cmd.wdata_sel = rc4_pkg::WD_CNT;
                cmd.cnt_inc   = 1'b1;
            end
            rc4_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    if (rc4_pkg::func_t'(func) == rc4_pkg::FUNC_KEY)
                    begin
                        cmd.cnt_clr  = 1'b1;
                        cmd.kidx_clr = 1'b1;
                        cmd.idx_clr  = 1'b1;
                    end
                end
            end
            rc4_pkg::ST_KS_RD_K:
            begin
                cmd.raddr_sel = rc4_pkg::RA_CNT;
            end
            rc4_pkg::ST_KS_RD_J:
            begin
                cmd.raddr_sel = rc4_pkg::RA_JKS;
                cmd.j_ks_upd  = 1'b1;
                cmd.si_load   = 1'b1;
            end
            rc4_pkg::ST_KS_WR_K:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = rc4_pkg::WA_CNT;
                cmd.wdata_sel = rc4_pkg::WD_RDATA;
            end
            rc4_pkg::ST_KS_WR_J:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = rc4_pkg::WA_J;
                cmd.wdata_sel = rc4_pkg::WD_SI;
                cmd.cnt_inc   = 1'b1;
                cmd.kidx_adv  = 1'b1;
                cmd.idx_clr   = status.cnt_last;
            end
            rc4_pkg::ST_PR_RD_I:
            begin
                cmd.raddr_sel = rc4_pkg::RA_INEXT;
                cmd.i_inc     = 1'b1;
            end
            rc4_pkg::ST_PR_RD_J:
            begin
                cmd.raddr_sel = rc4_pkg::RA_JPR;
                cmd.j_pr_upd  = 1'b1;
                cmd.si_load   = 1'b1;
            end
            rc4_pkg::ST_PR_WR_I:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = rc4_pkg::WA_I;
                cmd.wdata_sel = rc4_pkg::WD_RDATA;
                cmd.raddr_sel = rc4_pkg::RA_T;
                cmd.t_load    = 1'b1;
                cmd.sj_load   = 1'b1;
            end
            rc4_pkg::ST_PR_WR_J:
            begin
                cmd.mem_we    = 1'b1;
                cmd.waddr_sel = rc4_pkg::WA_J;
                cmd.wdata_sel = rc4_pkg::WD_SI;
                cmd.raddr_sel = rc4_pkg::RA_TREG;
                cmd.out_load  = slot_free;
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/rc4_checker.sv -----
// port-level checks for the rc4 stream cipher, bound to the top level
// depends on rc4_stream_cipher_defines.svh and rc4_pkg
`timescale 1ns / 1ps
`include "rc4_stream_cipher_defines.svh"

module rc4_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       func,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [rc4_pkg::BYTE_W-1:0] data_out
);

    // a pending result is neither dropped nor changed
    `RC4_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)
    `RC4_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(data_out))

    // one item at a time: never two accepts in a row
    `RC4_ASSERT_NOW(a_no_back_to_back, in_valid && in_ready, !$past(in_valid && in_ready))

    // a key schedule item never raises a result right after it is taken
    `RC4_ASSERT_NEXT(a_key_no_result, in_valid && in_ready && !out_valid && (func == rc4_pkg::FUNC_KEY), !out_valid)

endmodule

bind rc4_stream_cipher rc4_checker u_rc4_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .data_out  (data_out)
);
